// ===== rtl/pslim_pkg.sv =====
// pslim_pkg: types, codes and the address hash shared by the session limiter.
// No dependencies; every other file of the limiter but pslim_ram refers to this package.
`default_nettype none

package pslim_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 1024;
    localparam int unsigned DEF_HASH_BITS     = 9;
    localparam logic [15:0] DEF_SESSION_LIMIT = 16'd100;
    localparam logic [15:0] CNT_MAX           = 16'hFFFF;

    localparam logic [1:0] MODE_NEW     = 2'd0;
    localparam logic [1:0] MODE_CONFIRM = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;
    localparam logic [1:0] MODE_DESTROY = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_BLOCK   = 2'd1;
    localparam logic [1:0] EV_UNBLOCK = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_ENTRY,
        S_UHEAD,
        S_UWALK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] src_addr;
        logic        exempt;
        logic [9:0]  entry_index;
        logic        in_tracked;
        logic        in_confirmed;
        logic        idx_ok;
    } item_t;

    typedef struct packed {
        logic        drop;
        logic        now_tracked;
        logic [9:0]  assigned_entry;
        logic        now_confirmed;
        logic        passthru;
        logic [1:0]  block_event;
        logic [15:0] source_count;
    } res_t;

    typedef struct packed {
        logic clearing;
    } status_t;

    // XOR-fold the address in chunks of hb bits; at most eight chunks.
    function automatic logic [11:0] hash_fold(input logic [31:0] a, input int unsigned hb);
        logic [31:0] acc;
        acc = 32'd0;
        for (int k = 0; k < 8; k++)
        begin
            acc = acc ^ (a >> (k * hb));
        end
        return 12'(acc & ((32'd1 << hb) - 32'd1));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pslim_ram.sv =====
// pslim_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pslim_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pslim_front.sv =====
// pslim_front: accepts items, classifies them (hash, index range) and queues them.
// Depends on pslim_pkg.
`default_nettype none

module pslim_front #(
    parameter int unsigned TABLE_ENTRIES = pslim_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned HASH_BITS     = pslim_pkg::DEF_HASH_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            mode,
    input  wire logic [31:0]           src_addr,
    input  wire logic                  exempt,
    input  wire logic [9:0]            entry_index,
    input  wire logic                  in_tracked,
    input  wire logic                  in_confirmed,
    input  wire pslim_pkg::status_t    status,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output pslim_pkg::item_t           q_item,
    output logic      [HASH_BITS-1:0]  q_hash
);

    pslim_pkg::item_t     item_reg [2];
    logic [HASH_BITS-1:0] hash_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push, pop;
    pslim_pkg::item_t     new_item;

    assign in_ready = (count_reg != 2'd2) && !status.clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = item_reg[rd_ptr_reg];
    assign q_hash   = hash_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.mode         = mode;
        new_item.src_addr     = src_addr;
        new_item.exempt       = exempt;
        new_item.entry_index  = entry_index;
        new_item.in_tracked   = in_tracked;
        new_item.in_confirmed = in_confirmed;
        new_item.idx_ok       = (32'(entry_index) < 32'(TABLE_ENTRIES));
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= new_item;
            hash_reg[wr_ptr_reg] <= HASH_BITS'(pslim_pkg::hash_fold(src_addr, HASH_BITS));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pslim_back.sv =====
// pslim_back: sequencer over the entry, bucket and free-stack memories; holds the
// result register. Depends on pslim_pkg and pslim_ram.
`default_nettype none

module pslim_back #(
    parameter int unsigned TABLE_ENTRIES = pslim_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned HASH_BITS     = pslim_pkg::DEF_HASH_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [15:0]           session_limit,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire pslim_pkg::item_t      q_item,
    input  wire logic [HASH_BITS-1:0]  q_hash,
    output pslim_pkg::status_t         status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pslim_pkg::res_t            out_res
);

    localparam int unsigned AW      = $clog2(TABLE_ENTRIES);
    localparam int unsigned PW      = AW + 1;
    localparam int unsigned BUCKETS = 1 << HASH_BITS;
    localparam int unsigned CLR_LEN = (TABLE_ENTRIES > BUCKETS) ? TABLE_ENTRIES : BUCKETS;
    localparam int unsigned CW      = $clog2(CLR_LEN);
    localparam int unsigned ROW_W   = 1 + 32 + 16 + 16 + PW;
    localparam logic [PW-1:0] NIL   = PW'(TABLE_ENTRIES);

    pslim_pkg::state_t    state_reg, state_next;
    pslim_pkg::item_t     item_reg, item_next;
    logic [HASH_BITS-1:0] hash_reg, hash_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [AW-1:0]        walk_reg, walk_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        lnext_reg, lnext_next;
    logic [PW-1:0]        free_top_reg, free_top_next;
    logic [CW-1:0]        clr_reg, clr_next;
    pslim_pkg::res_t      res_reg, res_next;
    pslim_pkg::res_t      out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;

    logic                 e_we;
    logic [AW-1:0]        e_wa, e_ra;
    logic [ROW_W-1:0]     e_wd, e_rd;
    logic                 b_we;
    logic [HASH_BITS-1:0] b_wa, b_ra;
    logic [PW-1:0]        b_wd, b_rd;
    logic                 f_we;
    logic [AW-1:0]        f_wa, f_wd, f_ra, f_rd;

    logic                 r_use;
    logic [31:0]          r_key;
    logic [15:0]          r_att, r_conf;
    logic [PW-1:0]        r_next;
    logic [15:0]          att_inc, att_dec, conf_inc, conf_dec;
    logic                 key_hit, can_alloc, q_direct, free_last;
    logic [HASH_BITS-1:0] key_hash;

    pslim_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );

    pslim_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bucket_ram (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
    );

    pslim_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
    );

    // Row layout: in_use, key, attached, confirmed, chain next.
    assign r_use  = e_rd[ROW_W-1];
    assign r_key  = e_rd[ROW_W-2 -: 32];
    assign r_att  = e_rd[PW+31 -: 16];
    assign r_conf = e_rd[PW+15 -: 16];
    assign r_next = e_rd[PW-1:0];

    assign att_inc  = (r_att == pslim_pkg::CNT_MAX) ? r_att : r_att + 16'd1;
    assign att_dec  = (r_att != 16'd0) ? r_att - 16'd1 : r_att;
    assign conf_inc = (r_conf == pslim_pkg::CNT_MAX) ? r_conf : r_conf + 16'd1;
    assign conf_dec = (item_reg.in_confirmed && r_conf != 16'd0) ? r_conf - 16'd1 : r_conf;
    assign key_hit  = (r_key == item_reg.src_addr);
    assign can_alloc = (free_top_reg != {PW{1'b0}});
    assign key_hash = HASH_BITS'(pslim_pkg::hash_fold(r_key, HASH_BITS));
    assign free_last = (att_dec == 16'd0);
    assign q_direct = (q_item.mode == pslim_pkg::MODE_NEW) ? q_item.exempt
                                                          : !(q_item.in_tracked && q_item.idx_ok);
    assign f_ra     = AW'(free_top_reg - PW'(1));

    assign out_load        = (state_reg == pslim_pkg::S_RESULT) && (!out_valid_reg || out_ready);
    assign out_valid       = out_valid_reg;
    assign out_res         = out_reg;
    assign status.clearing = (state_reg == pslim_pkg::S_CLEAR);
    assign q_ready         = (state_reg == pslim_pkg::S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pslim_pkg::S_CLEAR:
            begin
                if (clr_reg == CW'(CLR_LEN - 1))
                begin
                    state_next = pslim_pkg::S_IDLE;
                end
            end
            pslim_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_direct)
                        state_next = pslim_pkg::S_RESULT;
                    else if (q_item.mode == pslim_pkg::MODE_NEW)
                        state_next = pslim_pkg::S_HEAD;
                    else
                        state_next = pslim_pkg::S_ENTRY;
                end
            end
            pslim_pkg::S_HEAD:
            begin
                state_next = (b_rd == NIL) ? pslim_pkg::S_RESULT : pslim_pkg::S_WALK;
            end
            pslim_pkg::S_WALK:
            begin
                if (key_hit || r_next == NIL)
                    state_next = pslim_pkg::S_RESULT;
            end
            pslim_pkg::S_ENTRY:
            begin
                if (r_use && item_reg.mode == pslim_pkg::MODE_DESTROY && free_last)
                    state_next = pslim_pkg::S_UHEAD;
                else
                    state_next = pslim_pkg::S_RESULT;
            end
            pslim_pkg::S_UHEAD:
            begin
                if (b_rd == PW'(cur_reg) || b_rd == NIL)
                    state_next = pslim_pkg::S_RESULT;
                else
                    state_next = pslim_pkg::S_UWALK;
            end
            pslim_pkg::S_UWALK:
            begin
                if (r_next == PW'(cur_reg) || r_next == NIL)
                    state_next = pslim_pkg::S_RESULT;
            end
            pslim_pkg::S_RESULT:
            begin
                if (out_load)
                    state_next = pslim_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pslim_pkg::S_IDLE;
            end
        endcase
    end

    // Memory controls and datapath.
    always_comb
    begin
        item_next     = item_reg;
        hash_next     = hash_reg;
        cur_next      = cur_reg;
        walk_next     = walk_reg;
        head_next     = head_reg;
        lnext_next    = lnext_reg;
        free_top_next = free_top_reg;
        clr_next      = clr_reg;
        res_next      = res_reg;
        e_we = 1'b0; e_wa = cur_reg; e_wd = e_rd; e_ra = cur_reg;
        b_we = 1'b0; b_wa = hash_reg; b_wd = NIL; b_ra = hash_reg;
        f_we = 1'b0; f_wa = AW'(free_top_reg); f_wd = cur_reg;
        case (state_reg)
            pslim_pkg::S_CLEAR:
            begin
                // Sweep: empty every entry and bucket, stack every index.
                clr_next = clr_reg + CW'(1);
                e_we = (32'(clr_reg) < 32'(TABLE_ENTRIES));
                e_wa = AW'(clr_reg);
                e_wd = {1'b0, 32'd0, 16'd0, 16'd0, NIL};
                f_we = e_we;
                f_wa = AW'(clr_reg);
                f_wd = AW'(clr_reg);
                b_we = (32'(clr_reg) < 32'(BUCKETS));
                b_wa = HASH_BITS'(clr_reg);
                b_wd = NIL;
                free_top_next = NIL;
            end
            pslim_pkg::S_IDLE:
            begin
                item_next = q_item;
                hash_next = q_hash;
                b_ra      = q_hash;
                cur_next  = AW'(q_item.entry_index);
                e_ra      = AW'(q_item.entry_index);
                res_next  = '0;
                if (q_item.mode == pslim_pkg::MODE_CONFIRM || q_item.mode == pslim_pkg::MODE_QUERY)
                    res_next.now_confirmed = q_item.in_confirmed;
            end
            pslim_pkg::S_HEAD, pslim_pkg::S_WALK:
            begin
                if (state_reg == pslim_pkg::S_HEAD)
                    head_next = b_rd;
                if (state_reg == pslim_pkg::S_WALK && key_hit)
                begin
                    e_we = 1'b1;
                    e_wa = cur_reg;
                    e_wd = {r_use, r_key, att_inc, r_conf, r_next};
                    res_next.drop           = (r_conf >= session_limit);
                    res_next.now_tracked    = 1'b1;
                    res_next.assigned_entry = 10'(cur_reg);
                    res_next.source_count   = r_conf;
                end
                else if ((state_reg == pslim_pkg::S_HEAD && b_rd == NIL) ||
                         (state_reg == pslim_pkg::S_WALK && r_next == NIL))
                begin
                    // Unknown source: if the free stack is not empty, pop a free entry and push it on the bucket.
                    if (can_alloc)
                    begin
                        e_we = 1'b1;
                        e_wa = f_rd;
                        e_wd = {1'b1, item_reg.src_addr, 16'd1, 16'd0,
                                (state_reg == pslim_pkg::S_HEAD) ? b_rd : head_reg};
                        b_we = 1'b1;
                        b_wa = hash_reg;
                        b_wd = PW'(f_rd);
                        free_top_next = free_top_reg - PW'(1);
                        res_next.now_tracked    = 1'b1;
                        res_next.assigned_entry = 10'(f_rd);
                    end
                end
                else
                begin
                    e_ra     = (state_reg == pslim_pkg::S_HEAD) ? AW'(b_rd) : AW'(r_next);
                    cur_next = e_ra;
                end
            end
            pslim_pkg::S_ENTRY:
            begin
                if (r_use)
                begin
                    case (item_reg.mode)
                        pslim_pkg::MODE_CONFIRM:
                        begin
                            res_next.now_tracked    = 1'b1;
                            res_next.assigned_entry = 10'(cur_reg);
                            res_next.now_confirmed  = 1'b1;
                            res_next.source_count   = r_conf;
                            if (!item_reg.in_confirmed)
                            begin
                                e_we = 1'b1;
                                e_wa = cur_reg;
                                e_wd = {r_use, r_key, r_att, conf_inc, r_next};
                                res_next.passthru     = 1'b1;
                                res_next.drop         = (conf_inc > session_limit);
                                res_next.block_event  = (conf_inc == session_limit) ?
                                                        pslim_pkg::EV_BLOCK : pslim_pkg::EV_NONE;
                                res_next.source_count = conf_inc;
                            end
                        end
                        pslim_pkg::MODE_QUERY:
                        begin
                            res_next.drop           = 1'b1;
                            res_next.now_tracked    = 1'b1;
                            res_next.assigned_entry = 10'(cur_reg);
                            res_next.source_count   = r_conf;
                        end
                        pslim_pkg::MODE_DESTROY:
                        begin
                            res_next.source_count = conf_dec;
                            res_next.block_event  = (conf_dec == session_limit - 16'd1) ?
                                                    pslim_pkg::EV_UNBLOCK : pslim_pkg::EV_NONE;
                            e_we = 1'b1;
                            e_wa = cur_reg;
                            e_wd = {!free_last, r_key, att_dec, conf_dec, r_next};
                            if (free_last)
                            begin
                                // Release the entry, then unlink it from its chain.
                                f_we          = 1'b1;
                                f_wa          = AW'(free_top_reg);
                                f_wd          = cur_reg;
                                free_top_next = free_top_reg + PW'(1);
                                lnext_next    = r_next;
                                hash_next     = key_hash;
                                b_ra          = key_hash;
                            end
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
            end
            pslim_pkg::S_UHEAD:
            begin
                if (b_rd == PW'(cur_reg))
                begin
                    b_we = 1'b1;
                    b_wa = hash_reg;
                    b_wd = lnext_reg;
                end
                else
                begin
                    e_ra      = AW'(b_rd);
                    walk_next = AW'(b_rd);
                end
            end
            pslim_pkg::S_UWALK:
            begin
                if (r_next == PW'(cur_reg))
                begin
                    e_we = 1'b1;
                    e_wa = walk_reg;
                    e_wd = {r_use, r_key, r_att, r_conf, lnext_reg};
                end
                else
                begin
                    e_ra      = AW'(r_next);
                    walk_next = AW'(r_next);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pslim_pkg::S_CLEAR;
            clr_reg       <= '0;
            free_top_reg  <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_top_reg  <= free_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        hash_reg  <= hash_next;
        cur_reg   <= cur_next;
        walk_reg  <= walk_next;
        head_reg  <= head_next;
        lnext_reg <= lnext_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    a_free_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= NIL)
        else $error("free stack pointer beyond table size");

    a_idle_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pslim_pkg::S_IDLE) |=> free_top_reg == $past(free_top_reg))
        else $error("free stack moved while sequencer idle");

    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.clearing) |-> free_top_reg == NIL)
        else $error("clearing pass ended without a full free stack");

endmodule

`default_nettype wire

// ===== rtl/per_source_session_limiter.sv =====
// per_source_session_limiter: top level; session-limit register, front queue and back
// sequencer. Depends on pslim_pkg, pslim_front, pslim_back (and pslim_ram below it).
//
//  channel  signals                          direction  item
//  in       in_valid / in_ready + 6 fields   input      one session event
//  out      out_valid / out_ready + 7 fields output     one verdict per event
//  cfg      cfg_valid / cfg_ready, cfg_data  input      new session_limit
//
// Each item is finished before the next leaves the queue. Exempt new items and untracked
// or out-of-range others go straight to the result; new items read the bucket head and walk
// its chain to a hit, or allocate at its head; confirm, query and destroy read the entry, and
// a freeing destroy walks the chain to unlink it, one link a cycle via the entry memory's single read port.
// Reset: a clearing pass empties entries and buckets and refills the free stack;
// in_ready stays low meanwhile.
// Stalls: a two-item queue lets input run ahead of the sequencer, and the result
// register holds one verdict while out_ready is low.
`default_nettype none

module per_source_session_limiter #(
    parameter int unsigned TABLE_ENTRIES = pslim_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned HASH_BITS     = pslim_pkg::DEF_HASH_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] src_addr,
    input  wire logic        exempt,
    input  wire logic [9:0]  entry_index,
    input  wire logic        in_tracked,
    input  wire logic        in_confirmed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             drop,
    output logic             now_tracked,
    output logic [9:0]       assigned_entry,
    output logic             now_confirmed,
    output logic             passthru,
    output logic [1:0]       block_event,
    output logic [15:0]      source_count
);

    logic [15:0]          limit_reg;
    logic                 q_valid, q_ready;
    pslim_pkg::item_t     q_item;
    logic [HASH_BITS-1:0] q_hash;
    pslim_pkg::status_t   status;
    pslim_pkg::res_t      res;

    // cfg_ready is tied high; the user must send limit writes only while idle, which goes unchecked here.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pslim_pkg::DEF_SESSION_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Front: accept, hash and queue items.
    pslim_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BITS(HASH_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .src_addr(src_addr), .exempt(exempt), .entry_index(entry_index),
        .in_tracked(in_tracked), .in_confirmed(in_confirmed),
        .status(status),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .q_hash(q_hash)
    );

    // Back: walk chains, update counts, allocate and free entries.
    pslim_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BITS(HASH_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .session_limit(limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .q_hash(q_hash),
        .status(status),
        .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
    );

    assign drop           = res.drop;
    assign now_tracked    = res.now_tracked;
    assign assigned_entry = res.assigned_entry;
    assign now_confirmed  = res.now_confirmed;
    assign passthru       = res.passthru;
    assign block_event    = res.block_event;
    assign source_count   = res.source_count;

endmodule

`default_nettype wire
